[hdl/meb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// meb_pkg
// Shared types, constants and helpers of the Mandelbrot escape band core.
// ---------------------------------------------------------------------------
package meb_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int FRAC_BITS_DEF  = 24;

    localparam int ITER_CELLS   = 2;
    localparam int ORIGIN_PIXEL = 400;
    localparam int SAT_IN_W     = 72;

    localparam logic signed [31:0] CENTER_REAL_RST = 32'sd19461571;
    localparam logic signed [31:0] CENTER_IMAG_RST = -32'sd1677722;
    localparam logic [23:0]        PIXEL_STEP_RST  = 24'd50332;
    localparam logic [7:0]         MAX_ITER_RST    = 8'd50;

    localparam logic [1:0] REG_CENTER_REAL = 2'd0;
    localparam logic [1:0] REG_CENTER_IMAG = 2'd1;
    localparam logic [1:0] REG_PIXEL_STEP  = 2'd2;
    localparam logic [1:0] REG_MAX_ITER    = 2'd3;

    localparam logic [7:0] BAND_LIM_RED    = 8'd4;
    localparam logic [7:0] BAND_LIM_ORANGE = 8'd8;
    localparam logic [7:0] BAND_LIM_YELLOW = 8'd14;
    localparam logic [7:0] BAND_LIM_GREEN  = 8'd25;

    localparam logic [2:0] BAND_RED    = 3'd0;
    localparam logic [2:0] BAND_ORANGE = 3'd1;
    localparam logic [2:0] BAND_YELLOW = 3'd2;
    localparam logic [2:0] BAND_GREEN  = 3'd3;
    localparam logic [2:0] BAND_BLUE   = 3'd4;

    // One point in flight around the ring of iteration cells
    typedef struct packed {
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic [7:0]         n;
        logic               done;
    } token_t;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [31:0] r;
        if (v[SAT_IN_W-1:31] == '0 || v[SAT_IN_W-1:31] == '1)
        begin
            r = v[31:0];
        end
        else if (v[SAT_IN_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    function automatic logic [2:0] band_of(input logic [7:0] n);
        logic [2:0] b;
        if (n < BAND_LIM_RED)
        begin
            b = BAND_RED;
        end
        else if (n < BAND_LIM_ORANGE)
        begin
            b = BAND_ORANGE;
        end
        else if (n < BAND_LIM_YELLOW)
        begin
            b = BAND_YELLOW;
        end
        else if (n < BAND_LIM_GREEN)
        begin
            b = BAND_GREEN;
        end
        else
        begin
            b = BAND_BLUE;
        end
        return b;
    endfunction

endpackage

[hdl/meb_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// meb_px_if / meb_res_if
// Valid/ready channels for pixel items and result items.
// ---------------------------------------------------------------------------
interface meb_px_if #(
    parameter int COORD_BITS = meb_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row_index;

    modport source (output valid, output column, output row_index, input ready);
    modport sink   (input valid, input column, input row_index, output ready);
endinterface

interface meb_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] band;
    logic [7:0] iteration_count;

    modport source (output valid, output band, output iteration_count, input ready);
    modport sink   (input valid, input band, input iteration_count, output ready);
endinterface

[hdl/meb_iter_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// meb_iter_cell
// One z = z^2 + c step in two stages: products, then escape and limit test and update.
// ---------------------------------------------------------------------------
module meb_iter_cell #(
    parameter int FRAC_BITS = meb_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  meb_pkg::token_t in_tok,
    input  logic [7:0]      max_iter,
    output logic            out_valid,
    output meb_pkg::token_t out_tok
);
    import meb_pkg::*;

    localparam logic [64:0] LIMIT = 65'd4 << (2 * FRAC_BITS);

    logic               s1_valid_reg;
    token_t             s1_tok_reg;
    logic signed [63:0] xx_reg;
    logic signed [63:0] yy_reg;
    logic signed [63:0] xy_reg;

    logic               out_valid_reg;
    token_t             out_tok_reg;
    token_t             out_tok_next;

    logic [64:0]        mag;
    logic               escaped;
    logic signed [64:0] re_diff;
    logic signed [64:0] re_shift;
    logic signed [65:0] re_sum;
    logic signed [63:0] im_shift;
    logic signed [64:0] im_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tok_reg  <= in_tok;
        xx_reg      <= 64'($signed(in_tok.zr)) * 64'($signed(in_tok.zr));
        yy_reg      <= 64'($signed(in_tok.zi)) * 64'($signed(in_tok.zi));
        xy_reg      <= 64'($signed(in_tok.zr)) * 64'($signed(in_tok.zi));
        out_tok_reg <= out_tok_next;
    end

    always_comb
    begin
        mag      = {1'b0, xx_reg} + {1'b0, yy_reg};
        escaped  = (mag >= LIMIT);
        re_diff  = 65'(xx_reg) - 65'(yy_reg);
        re_shift = re_diff >>> FRAC_BITS;
        re_sum   = 66'(re_shift) + 66'($signed(s1_tok_reg.cr));
        im_shift = xy_reg >>> (FRAC_BITS - 1);
        im_sum   = 65'(im_shift) + 65'($signed(s1_tok_reg.ci));

        out_tok_next = s1_tok_reg;
        if (s1_tok_reg.done || (s1_tok_reg.n >= max_iter) || escaped)
        begin
            out_tok_next.done = 1'b1;
        end
        else
        begin
            out_tok_next.zr = sat32(SAT_IN_W'(re_sum));
            out_tok_next.zi = sat32(SAT_IN_W'(im_sum));
            out_tok_next.n  = s1_tok_reg.n + 8'd1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

[hdl/mandelbrot_escape_band_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mandelbrot_escape_band_core
// Escape-time count and color band for one pixel of the Mandelbrot set.
// ---------------------------------------------------------------------------
// pixel_in carries column and row_index; result_out returns band and
// iteration_count, one result item per pixel item, in order.
// cfg_we/cfg_index/cfg_wdata write center_real (0), center_imag (1),
// pixel_step (2) and max_iterations (3); write only while the core is idle.
// One pixel is worked at a time. On acceptance the scaled pixel offsets
// are registered; the mapped point is then injected into a ring of
// ITER_CELLS two-stage iteration cells and circulates until it escapes or
// reaches max_iterations. pixel_in.ready rises at the same edge that
// registers the result, so the next pixel can be taken even while the
// previous result still waits. If the receiver stalls, the finished
// count is held until the output register frees up.
// Reset clears the pipeline and loads the default view and limit.
// ---------------------------------------------------------------------------
module mandelbrot_escape_band_core #(
    parameter int COORD_BITS = meb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = meb_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    meb_px_if.sink      pixel_in,
    meb_res_if.source   result_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import meb_pkg::*;

    localparam int POS_W  = ((COORD_BITS > 9) ? COORD_BITS : 9) + 1;
    localparam int PROD_W = POS_W + 25;
    localparam int DIFF_W = PROD_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic signed [31:0] center_real_reg, center_real_next;
    logic signed [31:0] center_imag_reg, center_imag_next;
    logic [23:0]        pixel_step_reg, pixel_step_next;
    logic [7:0]         max_iter_reg, max_iter_next;
    logic               res_valid_reg, res_valid_next;
    logic [2:0]         band_reg, band_next;
    logic [7:0]         count_reg, count_next;
    logic [7:0]         hold_n_reg, hold_n_next;

    logic signed [PROD_W-1:0] prod_re_reg;
    logic signed [PROD_W-1:0] prod_im_reg;
    logic signed [POS_W-1:0]  pos_re;
    logic signed [POS_W-1:0]  pos_im;
    logic signed [24:0]       step_s;
    logic signed [DIFF_W-1:0] diff_re;
    logic signed [DIFF_W-1:0] diff_im;

    logic   accept;
    logic   inject;
    logic   out_free;
    logic   last_done;
    token_t map_tok;

    logic   chain_valid [0:ITER_CELLS];
    token_t chain_tok   [0:ITER_CELLS];

    assign accept   = pixel_in.valid && pixel_in.ready;
    assign inject   = (state_reg == ST_MAP);
    assign out_free = !res_valid_reg || result_out.ready;

    assign pos_re = $signed(POS_W'(COORD_BITS'(pixel_in.column)))
                  - $signed(POS_W'(ORIGIN_PIXEL));
    assign pos_im = $signed(POS_W'(COORD_BITS'(pixel_in.row_index)))
                  - $signed(POS_W'(ORIGIN_PIXEL));
    assign step_s = $signed({1'b0, pixel_step_reg});

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_re_reg <= PROD_W'(pos_re) * PROD_W'(step_s);
            prod_im_reg <= PROD_W'(pos_im) * PROD_W'(step_s);
        end
    end

    assign diff_re = DIFF_W'(prod_re_reg) - DIFF_W'(center_real_reg);
    assign diff_im = DIFF_W'(prod_im_reg) - DIFF_W'(center_imag_reg);

    always_comb
    begin
        map_tok.zr   = '0;
        map_tok.zi   = '0;
        map_tok.cr   = sat32(SAT_IN_W'(diff_re));
        map_tok.ci   = sat32(SAT_IN_W'(diff_im));
        map_tok.n    = '0;
        map_tok.done = 1'b0;
    end

    // ring of iteration cells; finished points leave at the wrap
    assign last_done      = chain_valid[ITER_CELLS] && chain_tok[ITER_CELLS].done;
    assign chain_valid[0] = inject || (chain_valid[ITER_CELLS] && !chain_tok[ITER_CELLS].done);
    assign chain_tok[0]   = inject ? map_tok : chain_tok[ITER_CELLS];

    for (genvar k = 0; k < ITER_CELLS; k++)
    begin : g_cell
        meb_iter_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_tok    (chain_tok[k]),
            .max_iter  (max_iter_reg),
            .out_valid (chain_valid[k+1]),
            .out_tok   (chain_tok[k+1])
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        center_real_next = center_real_reg;
        center_imag_next = center_imag_reg;
        pixel_step_next  = pixel_step_reg;
        max_iter_next    = max_iter_reg;
        res_valid_next   = res_valid_reg;
        band_next        = band_reg;
        count_next       = count_reg;
        hold_n_next      = hold_n_reg;

        if (res_valid_reg && result_out.ready)
        begin
            res_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_REAL: center_real_next = $signed(cfg_wdata);
                REG_CENTER_IMAG: center_imag_next = $signed(cfg_wdata);
                REG_PIXEL_STEP:  pixel_step_next  = cfg_wdata[23:0];
                REG_MAX_ITER:    max_iter_next    = cfg_wdata[7:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (last_done)
                begin
                    hold_n_next = chain_tok[ITER_CELLS].n;
                    if (out_free)
                    begin
                        res_valid_next = 1'b1;
                        count_next     = chain_tok[ITER_CELLS].n;
                        band_next      = band_of(chain_tok[ITER_CELLS].n);
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    count_next     = hold_n_reg;
                    band_next      = band_of(hold_n_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            center_real_reg <= CENTER_REAL_RST;
            center_imag_reg <= CENTER_IMAG_RST;
            pixel_step_reg  <= PIXEL_STEP_RST;
            max_iter_reg    <= MAX_ITER_RST;
            res_valid_reg   <= 1'b0;
            band_reg        <= BAND_RED;
            count_reg       <= '0;
            hold_n_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            center_real_reg <= center_real_next;
            center_imag_reg <= center_imag_next;
            pixel_step_reg  <= pixel_step_next;
            max_iter_reg    <= max_iter_next;
            res_valid_reg   <= res_valid_next;
            band_reg        <= band_next;
            count_reg       <= count_next;
            hold_n_reg      <= hold_n_next;
        end
    end

    assign pixel_in.ready             = (state_reg == ST_IDLE);
    assign result_out.valid           = res_valid_reg;
    assign result_out.band            = band_reg;
    assign result_out.iteration_count = count_reg;

endmodule

[verif/mandelbrot_escape_band_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mandelbrot_escape_band_checker
// Watches the pixel, result and register ports of the escape band core,
// keeps its own copy of the view registers, works out the escape count and
// band of every accepted pixel item and compares each result item, field by
// field, with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module mandelbrot_escape_band_checker (
    input  logic        clk,
    input  logic        rst_n,
    meb_px_if           pixel_mon,
    meb_res_if          result_mon,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          checked_count,
    output logic [4:0]  bands_seen
);
    import meb_pkg::*;

    localparam int          FRAC       = FRAC_BITS_DEF;
    localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FRAC);
    localparam longint      Q_MAX      = 64'sd2147483647;
    localparam longint      Q_MIN      = -64'sd2147483648;

    typedef struct packed {
        logic [2:0] band;
        logic [7:0] count;
    } escape_t;

    logic signed [31:0] view_re    = CENTER_REAL_RST;
    logic signed [31:0] view_im    = CENTER_IMAG_RST;
    logic [23:0]        view_step  = PIXEL_STEP_RST;
    logic [7:0]         iter_limit = MAX_ITER_RST;

    escape_t    expected_escapes[$];
    int         fails    = 0;
    int         checked  = 0;
    int         waiting  = 0;
    logic [4:0] seen     = '0;

    assign fail_count    = fails;
    assign pending       = waiting;
    assign checked_count = checked;
    assign bands_seen    = seen;

    function automatic longint clamp32(input longint v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic logic [2:0] band_for(input int unsigned n);
        if (n < BAND_LIM_RED)
        begin
            return BAND_RED;
        end
        if (n < BAND_LIM_ORANGE)
        begin
            return BAND_ORANGE;
        end
        if (n < BAND_LIM_YELLOW)
        begin
            return BAND_YELLOW;
        end
        if (n < BAND_LIM_GREEN)
        begin
            return BAND_GREEN;
        end
        return BAND_BLUE;
    endfunction

    function automatic escape_t predict_escape(input logic [COORD_BITS_DEF-1:0] col,
                                               input logic [COORD_BITS_DEF-1:0] row);
        longint      cr;
        longint      ci;
        longint      x;
        longint      y;
        longint      xx;
        longint      yy;
        longint      xy;
        logic [63:0] mag;
        int unsigned n;
        bit          escaped;
        escape_t     r;
        cr = clamp32((longint'(col) - ORIGIN_PIXEL) * longint'(view_step) - longint'(view_re));
        ci = clamp32((longint'(row) - ORIGIN_PIXEL) * longint'(view_step) - longint'(view_im));
        x = 0;
        y = 0;
        n = 0;
        escaped = 1'b0;
        while (!escaped && n < iter_limit)
        begin
            xx  = x * x;
            yy  = y * y;
            xy  = x * y;
            mag = xx + yy;
            if (mag >= ESCAPE_MAG)
            begin
                escaped = 1'b1;
            end
            else
            begin
                x = clamp32(((xx - yy) >>> FRAC) + cr);
                y = clamp32((xy >>> (FRAC - 1)) + ci);
                n++;
            end
        end
        r.band  = band_for(n);
        r.count = n[7:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fails < 40)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        escape_t got;
        escape_t want;
        if (!rst_n)
        begin
            view_re    = CENTER_REAL_RST;
            view_im    = CENTER_IMAG_RST;
            view_step  = PIXEL_STEP_RST;
            iter_limit = MAX_ITER_RST;
            expected_escapes.delete();
            waiting = 0;
        end
        else
        begin
            if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1)
            begin
                got.band  = result_mon.band;
                got.count = result_mon.iteration_count;
                checked++;
                if (got.band <= BAND_BLUE)
                begin
                    seen[got.band] = 1'b1;
                end
                if (expected_escapes.size() == 0)
                begin
                    report_mismatch($sformatf("result item with nothing expected: band %0d count %0d",
                                              got.band, got.count));
                end
                else
                begin
                    want = expected_escapes.pop_front();
                    if (got.band !== want.band)
                    begin
                        report_mismatch($sformatf("band %0d, expected %0d (count expected %0d)",
                                                  got.band, want.band, want.count));
                    end
                    if (got.count !== want.count)
                    begin
                        report_mismatch($sformatf("iteration_count %0d, expected %0d",
                                                  got.count, want.count));
                    end
                end
            end
            if (pixel_mon.valid === 1'b1 && pixel_mon.ready === 1'b1)
            begin
                expected_escapes.push_back(predict_escape(pixel_mon.column, pixel_mon.row_index));
            end
            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    REG_CENTER_REAL: view_re    = cfg_wdata;
                    REG_CENTER_IMAG: view_im    = cfg_wdata;
                    REG_PIXEL_STEP:  view_step  = cfg_wdata[23:0];
                    REG_MAX_ITER:    iter_limit = cfg_wdata[7:0];
                    default:         ;
                endcase
            end
            waiting = expected_escapes.size();
        end
    end

endmodule

[verif/mandelbrot_escape_band_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mandelbrot_escape_band_core_tb
// Drives pixel items into the escape band core under a series of views:
// reset defaults, random views near the set boundary, zero and one
// iteration limits, the full limit and saturating far-out views. The
// sender idles in bursts, the receiver stalls on its own pattern, and once
// it holds off long enough to back the core up. Checking is done by the
// checker module; this module gives the verdict.
// ---------------------------------------------------------------------------
module mandelbrot_escape_band_core_tb;
    import meb_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int HOLD_CYCLES    = 400;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_e;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    bit          hold_req;
    bit          gaps_on;
    int unsigned burst_left;
    int          settings_count;
    int          sent_count;

    int          fail_count;
    int          pending;
    int          checked_count;
    logic [4:0]  bands_seen;

    meb_px_if  pixel_bus ();
    meb_res_if result_bus ();

    mandelbrot_escape_band_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pixel_bus),
        .result_out (result_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    mandelbrot_escape_band_checker escape_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_mon     (pixel_bus),
        .result_mon    (result_bus),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .bands_seen    (bands_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned tick;
        rx_mode_e    mode;
        hold_left = 0;
        mode_left = 0;
        tick = 0;
        mode = RX_ALWAYS;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (mode_left == 0)
            begin
                mode = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 400);
            end
            else
            begin
                mode_left--;
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS:   result_bus.ready <= 1'b1;
                    RX_COIN:     result_bus.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: result_bus.ready <= ((tick % 7) >= 3);
                    default:     result_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_bus.valid === 1'b1 && pixel_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_pixel(input logic [COORD_BITS_DEF-1:0] col,
                              input logic [COORD_BITS_DEF-1:0] row);
        int unsigned gap;
        pixel_bus.valid     <= 1'b1;
        pixel_bus.column    <= col;
        pixel_bus.row_index <= row;
        @(posedge clk);
        while (pixel_bus.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sent_count++;
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(1, 15);
                burst_left = $urandom_range(0, 11);
                pixel_bus.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // mostly the area near the origin pixel, a quarter anywhere
    task automatic send_random_pixels(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_pixel(COORD_BITS_DEF'($urandom_range(0, 2047)),
                           COORD_BITS_DEF'($urandom_range(0, 2047)));
            end
            else
            begin
                send_pixel(COORD_BITS_DEF'($urandom_range(0, 800)),
                           COORD_BITS_DEF'($urandom_range(0, 800)));
            end
        end
    endtask

    task automatic wait_results_drained();
        pixel_bus.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic program_view(input logic signed [31:0] re, input logic signed [31:0] im,
                                input logic [23:0] step, input logic [7:0] iter);
        logic [31:0] junk;
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= REG_CENTER_REAL;
        cfg_wdata <= re;
        @(negedge clk);
        cfg_index <= REG_CENTER_IMAG;
        cfg_wdata <= im;
        @(negedge clk);
        cfg_index <= REG_PIXEL_STEP;
        cfg_wdata <= {junk[31:24], step};
        @(negedge clk);
        cfg_index <= REG_MAX_ITER;
        cfg_wdata <= {junk[23:0], iter};
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // center from -0.5..1.5 real, -1..1 imaginary; small steps
    task automatic program_random_view(input logic [7:0] iter);
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [23:0]        step;
        re   = $signed($urandom_range(0, 33554432)) - 32'sd8388608;
        im   = $signed($urandom_range(0, 33554432)) - 32'sd16777216;
        step = 24'($urandom_range(2000, 200000));
        program_view(re, im, step, iter);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_CENTER_REAL;
        cfg_wdata           = '0;
        pixel_bus.valid     = 1'b0;
        pixel_bus.column    = '0;
        pixel_bus.row_index = '0;
        hold_req            = 1'b0;
        gaps_on             = 1'b1;
        burst_left          = 0;
        settings_count      = 0;
        sent_count          = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset view: corners, origin pixel, alternating bits
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd2047);
        send_pixel(11'd0, 11'd2047);
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd400, 11'd400);
        send_pixel(11'h555, 11'h2AA);
        send_pixel(11'h2AA, 11'h555);
        send_pixel(11'd300, 11'd420);
        wait_results_drained();

        // zero limit: no iteration at all
        program_view(CENTER_REAL_RST, CENTER_IMAG_RST, PIXEL_STEP_RST, 8'd0);
        send_pixel(11'd400, 11'd400);
        send_pixel(11'd2047, 11'd0);
        wait_results_drained();

        program_view(CENTER_REAL_RST, CENTER_IMAG_RST, PIXEL_STEP_RST, 8'd1);
        send_pixel(11'd400, 11'd400);
        send_pixel(11'd0, 11'd0);
        wait_results_drained();

        // far out: c saturates at the range ends
        program_view(32'sh8000_0000, 32'sh7fff_ffff, 24'hff_ffff, MAX_ITER_RST);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd2047);
        send_pixel(11'd400, 11'd400);
        wait_results_drained();
        program_view(32'sh7fff_ffff, 32'sh8000_0000, 24'hff_ffff, MAX_ITER_RST);
        send_pixel(11'd0, 11'd2047);
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd400, 11'd400);
        wait_results_drained();

        // c = 0 never escapes: runs to the full limit
        program_view(32'sd0, 32'sd0, 24'd0, 8'd255);
        send_pixel(11'd1234, 11'd77);
        wait_results_drained();

        program_view(CENTER_REAL_RST, CENTER_IMAG_RST, PIXEL_STEP_RST, MAX_ITER_RST);
        send_random_pixels(90);
        wait_results_drained();

        // receiver holds off while the sender keeps offering
        program_random_view(8'($urandom_range(1, 80)));
        hold_req = 1'b1;
        gaps_on = 1'b0;
        send_random_pixels(80);
        wait_results_drained();

        for (int unsigned p = 0; p < 6; p++)
        begin
            gaps_on = p[0];
            program_random_view(8'($urandom_range(1, 80)));
            send_random_pixels(70);
            wait_results_drained();
        end
        gaps_on = 1'b1;

        program_random_view(8'd255);
        send_random_pixels(40);
        wait_results_drained();

        program_view(32'sh7fff_ffff, 32'sh7fff_ffff, 24'hff_ffff,
                     8'($urandom_range(1, 255)));
        send_random_pixels(30);
        wait_results_drained();
        program_view(32'sh8000_0000, 32'sh8000_0000, 24'hff_ffff,
                     8'($urandom_range(1, 255)));
        send_random_pixels(20);
        wait_results_drained();

        program_random_view(8'd0);
        send_random_pixels(20);
        wait_results_drained();

        repeat (12) @(negedge clk);
        $display("summary: %0d pixel items sent, %0d result items checked",
                 sent_count, checked_count);
        $display("summary: %0d register settings, bands seen %b", settings_count, bands_seen);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[mandelbrot_escape_band_core.f]
hdl/meb_pkg.sv
hdl/meb_if.sv
hdl/meb_iter_cell.sv
hdl/mandelbrot_escape_band_core.sv
verif/mandelbrot_escape_band_checker.sv
verif/mandelbrot_escape_band_core_tb.sv
